// ===== rtl/clnb_pkg.sv =====
// ----------------------------------------------------------------------------
// clnb_pkg
// shared types, constants and request codes for the cell list binning block
// ----------------------------------------------------------------------------
package clnb_pkg;

  localparam int MaxGrid      = 16;
  localparam int CellCapacity = 8;
  localparam int CoordW       = $clog2(MaxGrid);
  localparam int CellIdxW     = 3 * CoordW;
  localparam int SlotW        = $clog2(CellCapacity);
  localparam int CountW       = $clog2(CellCapacity + 1);
  localparam int SlotAddrW    = CellIdxW + SlotW;
  localparam int IdW          = 10;
  localparam int GridW        = 5;
  localparam int PosW         = 32;
  localparam int NumCells     = MaxGrid * MaxGrid * MaxGrid;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [2:0] CFG_GRID_X    = 3'd0;
  localparam logic [2:0] CFG_GRID_Y    = 3'd1;
  localparam logic [2:0] CFG_GRID_Z    = 3'd2;
  localparam logic [2:0] CFG_CELL_SIZE = 3'd3;
  localparam logic [2:0] CFG_TWO_DIM   = 3'd4;

  // result beat fields
  typedef struct packed {
    logic       last;
    logic       near_edge;
    logic [1:0] status;
    logic [IdW-1:0] found_id;
    logic [CountW-1:0] count;
    logic [CoordW-1:0] cell_z;
    logic [CoordW-1:0] cell_y;
    logic [CoordW-1:0] cell_x;
  } result_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic [PosW-1:0] px;
    logic [PosW-1:0] py;
    logic [PosW-1:0] pz;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] cz;
  } div_rsp_t;

  function automatic logic [GridW-1:0] eff_grid(input logic [GridW-1:0] g);
    if (g == '0) return GridW'(1);
    if (g > GridW'(MaxGrid)) return GridW'(MaxGrid);
    return g;
  endfunction

endpackage

// ===== rtl/cell_list_neighbor_binning_top.sv =====
// ----------------------------------------------------------------------------
// cell_list_neighbor_binning_top
// bins particles into a cell grid and lists neighbor cells on query
// ----------------------------------------------------------------------------
// insert and query first run a serial divide; an insert then reads the cell count
//   (S_INS_RD, S_INS_WR) and gives one beat, a query reads each neighbor count
//   (S_Q_RD, S_Q_OUT) and gives one beat per neighbor, up to 27 beats, with an
//   extra S_Q_RD pass per column with z clipped below; a slot read runs S_RD_RD
//   then S_RD_OUT; only one item is in flight at a time, beats wait on m_tready
// reset: a clearing pass over all 4096 cells zeroes the count memory, as does a clear
module cell_list_neighbor_binning_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // req_type[1:0], pos_x[33:2], pos_y[65:34], pos_z[97:66], particle_id[107:98],
  // sel_cell_x[111:108], sel_cell_y[115:112], sel_cell_z[119:116], slot[122:120]
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // cell_x[3:0], cell_y[7:4], cell_z[11:8], count[15:12], found_id[25:16],
  // status[27:26], near_edge[28]
  output logic [31:0]  m_tdata,
  output logic         m_tlast
);
  import clnb_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_INS_RD, S_INS_WR, S_Q_RD, S_Q_OUT,
    S_RD_RD, S_RD_OUT, S_WAIT
  } state_t;

  // configuration registers
  logic [GridW-1:0] grid_x, grid_y, grid_z;
  logic [PosW-1:0]  cell_size;
  logic             two_dim;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_x <= GridW'(16);
      grid_y <= GridW'(16);
      grid_z <= GridW'(16);
      cell_size <= 32'd65536;
      two_dim <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_X:    grid_x <= cfg_data[GridW-1:0];
        CFG_GRID_Y:    grid_y <= cfg_data[GridW-1:0];
        CFG_GRID_Z:    grid_z <= cfg_data[GridW-1:0];
        CFG_CELL_SIZE: cell_size <= cfg_data;
        CFG_TWO_DIM:   two_dim <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [GridW-1:0] gx, gy, gz;
  assign gx = eff_grid(grid_x);
  assign gy = two_dim ? GridW'(1) : eff_grid(grid_y);
  assign gz = eff_grid(grid_z);

  state_t state;
  logic [CellIdxW-1:0] clr_idx;
  logic [1:0]  req;
  logic [IdW-1:0] pid;
  logic [CoordW-1:0] sx, sy, sz;
  logic [SlotW-1:0] sl;
  logic [CoordW-1:0] cx, cy, cz;
  logic edge_q;
  logic in_grid;
  // neighbor walk offsets, 0/1/2 meaning -1/0/+1
  logic [1:0] ox, oy, oz;
  logic [CoordW-1:0] nx, ny, nz;
  logic [CoordW-1:0] rnx, rny, rnz;
  logic last_pend;
  result_t res;
  logic out_valid;

  div_req_t dreq;
  div_rsp_t drsp;

  clnb_div u_div (
    .clk, .rst, .req(dreq), .cell_size, .gx, .gy, .gz, .rsp(drsp)
  );

  logic [CellIdxW-1:0]  cnt_raddr, cnt_waddr;
  logic [CountW-1:0]    cnt_rdata, cnt_wdata;
  logic                 cnt_we;
  logic [SlotAddrW-1:0] slot_raddr, slot_waddr;
  logic [IdW-1:0]       slot_rdata;
  logic                 slot_we;

  clnb_store u_store (
    .clk, .cnt_raddr, .cnt_rdata, .cnt_we, .cnt_waddr, .cnt_wdata,
    .slot_raddr, .slot_rdata, .slot_we, .slot_waddr, .slot_wdata(pid)
  );

  // neighbor coordinates for the current offsets, wrap x/y, z stays in range
  logic [GridW-1:0] gxm, gym;
  assign gxm = gx - GridW'(1);
  assign gym = gy - GridW'(1);
  always_comb begin
    case (ox)
      2'd0:    nx = (cx == '0) ? gxm[CoordW-1:0] : cx - CoordW'(1);
      2'd2:    nx = (GridW'(cx) + GridW'(1) >= gx) ? '0 : cx + CoordW'(1);
      default: nx = cx;
    endcase
    case (oy)
      2'd0:    ny = (cy == '0) ? gym[CoordW-1:0] : cy - CoordW'(1);
      2'd2:    ny = (GridW'(cy) + GridW'(1) >= gy) ? '0 : cy + CoordW'(1);
      default: ny = cy;
    endcase
    case (oz)
      2'd0:    nz = cz - CoordW'(1);
      2'd2:    nz = cz + CoordW'(1);
      default: nz = cz;
    endcase
  end

  // offset range limits
  logic [1:0] oz_lo, oz_hi, oy_lo, oy_hi;
  assign oz_lo = (cz == '0) ? 2'd1 : 2'd0;
  assign oz_hi = (GridW'(cz) + GridW'(1) >= gz) ? 2'd1 : 2'd2;
  assign oy_lo = two_dim ? 2'd1 : 2'd0;
  assign oy_hi = two_dim ? 2'd1 : 2'd2;
  logic walk_end;
  assign walk_end = (ox == 2'd2) && (oy == oy_hi) && (oz == oz_hi);

  always_comb begin
    cnt_raddr = {nx, ny, nz};
    if (state == S_IDLE) cnt_raddr = {s_tdata[111:108], s_tdata[115:112],
                                      s_tdata[119:116]};
    else if (state == S_RD_RD || state == S_RD_OUT) cnt_raddr = {sx, sy, sz};
    else if (state == S_INS_RD || state == S_INS_WR || state == S_DIV)
      cnt_raddr = (state == S_DIV) ? {drsp.cx, drsp.cy, drsp.cz} : {cx, cy, cz};
  end
  assign slot_raddr = {sx, sy, sz, sl};
  assign slot_waddr = {cx, cy, cz, cnt_rdata[SlotW-1:0]};
  assign slot_we = (state == S_INS_WR) && (cnt_rdata < CountW'(CellCapacity));
  assign cnt_we = (state == S_CLEAR) || slot_we;
  assign cnt_waddr = (state == S_CLEAR) ? clr_idx : {cx, cy, cz};
  assign cnt_wdata = (state == S_CLEAR) ? '0 : cnt_rdata + CountW'(1);

  assign s_tready = (state == S_IDLE) && !out_valid;
  assign dreq.start = s_tvalid && s_tready &&
                      (s_tdata[1:0] == REQ_INSERT || s_tdata[1:0] == REQ_QUERY);
  assign dreq.px = s_tdata[33:2];
  assign dreq.py = s_tdata[65:34];
  assign dreq.pz = s_tdata[97:66];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + CellIdxW'(1);
          if (clr_idx == CellIdxW'(NumCells - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            req <= s_tdata[1:0];
            pid <= s_tdata[107:98];
            sx <= s_tdata[111:108];
            sy <= s_tdata[115:112];
            sz <= s_tdata[119:116];
            sl <= s_tdata[122:120];
            in_grid <= (GridW'(s_tdata[111:108]) < gx) &&
                       (GridW'(s_tdata[115:112]) < gy) &&
                       (GridW'(s_tdata[119:116]) < gz);
            case (s_tdata[1:0])
              REQ_CLEAR: begin
                clr_idx <= '0;
                state <= S_CLEAR;
              end
              REQ_READ: state <= S_RD_RD;
              default:  state <= S_DIV;
            endcase
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            cx <= drsp.cx;
            cy <= two_dim ? '0 : drsp.cy;
            cz <= drsp.cz;
            edge_q <= (drsp.cx == '0) || (GridW'(drsp.cx) >= gxm) ||
                      (!two_dim && ((drsp.cy == '0) || (GridW'(drsp.cy) >= gym)));
            ox <= 2'd0;
            oy <= two_dim ? 2'd1 : 2'd0;
            oz <= 2'd0;
            state <= (req == REQ_INSERT) ? S_INS_RD : S_Q_RD;
          end
        end
        S_INS_RD: state <= S_INS_WR;
        S_INS_WR: begin
          res.cell_x <= cx;
          res.cell_y <= cy;
          res.cell_z <= cz;
          res.found_id <= '0;
          res.near_edge <= 1'b0;
          res.last <= 1'b1;
          if (cnt_rdata >= CountW'(CellCapacity)) begin
            res.count <= cnt_rdata;
            res.status <= ST_FULL;
          end else begin
            res.count <= cnt_rdata + CountW'(1);
            res.status <= ST_OK;
          end
          out_valid <= 1'b1;
          state <= S_WAIT;
        end
        S_Q_RD: begin
          // address for this neighbor is on the count read port now
          if (oz == 2'd0 && oz_lo != 2'd0) oz <= oz_lo;
          rnx <= nx;
          rny <= ny;
          rnz <= nz;
          last_pend <= walk_end;
          if (!(oz == 2'd0 && oz_lo != 2'd0)) state <= S_Q_OUT;
        end
        S_Q_OUT: begin
          if (!out_valid || m_tready) begin
            res.cell_x <= rnx;
            res.cell_y <= rny;
            res.cell_z <= rnz;
            res.count <= cnt_rdata;
            res.found_id <= '0;
            res.status <= ST_OK;
            res.near_edge <= edge_q;
            res.last <= last_pend;
            out_valid <= 1'b1;
            if (last_pend) begin
              state <= S_WAIT;
            end else begin
              state <= S_Q_RD;
              if (oz == oz_hi) begin
                oz <= 2'd0;
                if (oy == oy_hi) begin
                  oy <= oy_lo;
                  ox <= ox + 2'd1;
                end else begin
                  oy <= oy + 2'd1;
                end
              end else begin
                oz <= oz + 2'd1;
              end
            end
          end
        end
        S_RD_RD: state <= S_RD_OUT;
        S_RD_OUT: begin
          res.cell_x <= sx;
          res.cell_y <= sy;
          res.cell_z <= sz;
          res.near_edge <= 1'b0;
          res.last <= 1'b1;
          if (!in_grid) begin
            res.count <= '0;
            res.found_id <= '0;
            res.status <= ST_EMPTY;
          end else if (CountW'(sl) >= cnt_rdata) begin
            res.count <= cnt_rdata;
            res.found_id <= '0;
            res.status <= ST_EMPTY;
          end else begin
            res.count <= cnt_rdata;
            res.found_id <= slot_rdata;
            res.status <= ST_OK;
          end
          out_valid <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: if (!out_valid || m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = res.last;
  assign m_tdata  = {3'b000, res.near_edge, res.status, res.found_id, res.count,
                     res.cell_z, res.cell_y, res.cell_x};
endmodule

// ===== rtl/clnb_div.sv =====
// ----------------------------------------------------------------------------
// clnb_div
// restoring divider, one quotient bit per cycle, three axes side by side
// ----------------------------------------------------------------------------
module clnb_div (
  input  logic clk,
  input  logic rst,
  input  clnb_pkg::div_req_t req,
  input  logic [clnb_pkg::PosW-1:0] cell_size,
  input  logic [clnb_pkg::GridW-1:0] gx,
  input  logic [clnb_pkg::GridW-1:0] gy,
  input  logic [clnb_pkg::GridW-1:0] gz,
  output clnb_pkg::div_rsp_t rsp
);
  import clnb_pkg::*;

  localparam int StepW = $clog2(PosW + 1);

  logic [StepW-1:0] step;
  logic busy;
  logic [PosW-1:0] num [3];
  logic [PosW-1:0] quo [3];
  logic [PosW:0]   rem [3];
  logic [PosW:0]   rs  [3];
  logic [GridW-1:0] g  [3];

  assign g[0] = gx;
  assign g[1] = gy;
  assign g[2] = gz;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rs[a] = {rem[a][PosW-1:0], num[a][PosW-1]};
    end
  end

  // saturate to grid minus one; zero cell size always saturates
  function automatic logic [CoordW-1:0] sat(input logic [PosW-1:0] q,
                                            input logic [GridW-1:0] gg,
                                            input logic zero);
    logic [GridW-1:0] gm;
    gm = gg - GridW'(1);
    if (zero || q >= PosW'(gg)) return gm[CoordW-1:0];
    return q[CoordW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        num[0] <= req.px;
        num[1] <= req.py;
        num[2] <= req.pz;
        for (int a = 0; a < 3; a++) begin
          rem[a] <= '0;
          quo[a] <= '0;
        end
      end else if (busy) begin
        for (int a = 0; a < 3; a++) begin
          num[a] <= {num[a][PosW-2:0], 1'b0};
          if (rs[a] >= {1'b0, cell_size}) begin
            rem[a] <= rs[a] - {1'b0, cell_size};
            quo[a] <= {quo[a][PosW-2:0], 1'b1};
          end else begin
            rem[a] <= rs[a];
            quo[a] <= {quo[a][PosW-2:0], 1'b0};
          end
        end
        if (step == StepW'(PosW)) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.cx <= sat(quo[0], g[0], cell_size == '0);
          rsp.cy <= sat(quo[1], g[1], cell_size == '0);
          rsp.cz <= sat(quo[2], g[2], cell_size == '0);
        end else begin
          step <= step + StepW'(1);
        end
      end
    end
  end
endmodule

// ===== rtl/clnb_store.sv =====
// ----------------------------------------------------------------------------
// clnb_store
// count and slot memories with registered read ports
// ----------------------------------------------------------------------------
module clnb_store (
  input  logic clk,
  input  logic [clnb_pkg::CellIdxW-1:0]  cnt_raddr,
  output logic [clnb_pkg::CountW-1:0]    cnt_rdata,
  input  logic                           cnt_we,
  input  logic [clnb_pkg::CellIdxW-1:0]  cnt_waddr,
  input  logic [clnb_pkg::CountW-1:0]    cnt_wdata,
  input  logic [clnb_pkg::SlotAddrW-1:0] slot_raddr,
  output logic [clnb_pkg::IdW-1:0]       slot_rdata,
  input  logic                           slot_we,
  input  logic [clnb_pkg::SlotAddrW-1:0] slot_waddr,
  input  logic [clnb_pkg::IdW-1:0]       slot_wdata
);
  import clnb_pkg::*;

  logic [CountW-1:0] cnt_mem  [NumCells];
  logic [IdW-1:0]    slot_mem [NumCells*CellCapacity];

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rdata <= slot_mem[slot_raddr];
  end
endmodule

// ===== rtl/clnb_checker.sv =====
// ----------------------------------------------------------------------------
// clnb_checker
// port-level checks on the binning block
// ----------------------------------------------------------------------------
module clnb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[27:26] != 2'd3)
    else $error("bad status code");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:12] <= 4'd8)
    else $error("count above capacity");

  a_no_take: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken mid result run");

  a_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[27:26] != 2'd0 |-> m_tdata[25:16] == 10'd0)
    else $error("id on failed result");
endmodule

bind cell_list_neighbor_binning_top clnb_checker u_clnb_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
